### hw/rtl/hs2d_pkg.sv
// Shared constants, register codes and item types of the heat stencil block.
package hs2d_pkg;

   // Grid limits and the derived line store geometry
   localparam int MAX_ROWS    = 1024;
   localparam int MAX_COLS    = 1024;
   localparam int STORE_DEPTH = MAX_COLS + 2;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int ROW_W       = $clog2(MAX_ROWS + 2);
   localparam int FILL_W      = $clog2(STORE_DEPTH + 1);

   // Field widths
   localparam int VALUE_W    = 32;
   localparam int IDX_W      = 11;
   localparam int SIZE_W     = 11;
   localparam int COEF_W     = 16;
   localparam int SIZE_RESET = 256;

   // Datapath widths: second difference, product, rounded sum, saturation input
   localparam int DIFF_W = VALUE_W + 3;
   localparam int PROD_W = DIFF_W + COEF_W + 1;
   localparam int SUM_W  = PROD_W + 1;
   localparam int FRAC_W = 16;
   localparam int QUO_W  = SUM_W - FRAC_W;
   localparam int SAT_W  = QUO_W + 1;

   // Result queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // Register file
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_GRID_ROWS = 2'd0,
      REG_GRID_COLS = 2'd1,
      REG_COEF_X    = 2'd2,
      REG_COEF_Y    = 2'd3
   } reg_index_type;

   // Position data that travels alongside the arithmetic
   typedef struct packed {
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic             last;
   } meta_type;

   // One result item
   typedef struct packed {
      logic signed [VALUE_W-1:0] new_value;
      logic [IDX_W-1:0]          out_row;
      logic [IDX_W-1:0]          out_col;
      logic                      last_of_grid;
   } rsp_item_type;

endpackage

### hw/rtl/hs2d_arith.sv
// Stencil arithmetic pipeline: coefficient products, rounding and saturation.
module hs2d_arith (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      in_valid,
   input  logic signed [hs2d_pkg::DIFF_W-1:0]         in_dv,
   input  logic signed [hs2d_pkg::DIFF_W-1:0]         in_dh,
   input  logic signed [hs2d_pkg::VALUE_W-1:0]        in_p,
   input  hs2d_pkg::meta_type                         in_meta,
   input  logic [hs2d_pkg::COEF_W-1:0]                coef_x,
   input  logic [hs2d_pkg::COEF_W-1:0]                coef_y,
   output logic                                      out_valid,
   output hs2d_pkg::rsp_item_type                     out_item,
   output logic [1:0]                                busy_count
);
   import hs2d_pkg::*;

   logic                      v2_ff, v3_ff, v4_ff;
   logic signed [DIFF_W-1:0]  dv2_ff, dh2_ff;
   logic signed [VALUE_W-1:0] p2_ff, p3_ff, p4_ff;
   meta_type                  meta2_ff, meta3_ff, meta4_ff;
   logic signed [PROD_W-1:0]  px3_ff, py3_ff;
   logic signed [PROD_W-1:0]  px_in, py_in;
   logic signed [SUM_W-1:0]   sum;
   logic signed [QUO_W-1:0]   q4_ff;
   logic signed [SAT_W-1:0]   total;
   logic signed [VALUE_W-1:0] sat_value;

   // Advance the valid bits of the three stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v2_ff <= in_valid;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Stage 2: capture the second differences
   always_ff @(posedge clock) begin
      dv2_ff   <= in_dv;
      dh2_ff   <= in_dh;
      p2_ff    <= in_p;
      meta2_ff <= in_meta;
   end

   // Stage 3: one coefficient product per axis
   always_comb begin
      px_in = $signed({1'b0, coef_x}) * dv2_ff;
      py_in = $signed({1'b0, coef_y}) * dh2_ff;
   end

   always_ff @(posedge clock) begin
      px3_ff   <= px_in;
      py3_ff   <= py_in;
      p3_ff    <= p2_ff;
      meta3_ff <= meta2_ff;
   end

   // Stage 4: sum, add half an LSB and floor to Q16.16
   always_comb begin
      sum = SUM_W'(px3_ff) + SUM_W'(py3_ff) + SUM_W'(32768);
   end

   always_ff @(posedge clock) begin
      q4_ff    <= sum[SUM_W-1:FRAC_W];
      p4_ff    <= p3_ff;
      meta4_ff <= meta3_ff;
   end

   // Add the center value and clip to the signed 32-bit range
   always_comb begin
      total = {{(SAT_W-VALUE_W){p4_ff[VALUE_W-1]}}, p4_ff} + SAT_W'(q4_ff);
      if (total > SAT_W'(34'sh0_7FFF_FFFF)) begin
         sat_value = {1'b0, {(VALUE_W-1){1'b1}}};
      end else if (total < -SAT_W'(34'sh0_8000_0000)) begin
         sat_value = {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
         sat_value = total[VALUE_W-1:0];
      end
   end

   always_comb begin
      out_valid             = v4_ff;
      out_item.new_value    = sat_value;
      out_item.out_row      = meta4_ff.row;
      out_item.out_col      = meta4_ff.col;
      out_item.last_of_grid = meta4_ff.last;
      busy_count            = 2'(v2_ff) + 2'(v3_ff) + 2'(v4_ff);
   end

endmodule

### hw/rtl/hs2d_rsp_fifo.sv
// Result queue that decouples the stencil pipeline from the receiver.
module hs2d_rsp_fifo (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   input  hs2d_pkg::rsp_item_type                 push_item,
   input  logic                                  pop,
   output logic                                  head_valid,
   output hs2d_pkg::rsp_item_type                 head_item,
   output logic [hs2d_pkg::FIFO_CNT_W-1:0]        count
);
   import hs2d_pkg::*;

   rsp_item_type            entries_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0]   count_ff;
   logic                    do_pop;

   assign do_pop     = pop && (count_ff != '0);
   assign head_valid = (count_ff != '0);
   assign head_item  = entries_ff[rd_ptr_ff];
   assign count      = count_ff;

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + FIFO_CNT_W'(1);
         end else if (!push && do_pop) begin
            count_ff <= count_ff - FIFO_CNT_W'(1);
         end
      end
   end

   // A push never lands in a full queue unless an item pops in the same cycle
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < FIFO_CNT_W'(FIFO_DEPTH)) || do_pop)
      else $error("result queue overflow");

   // Occupancy tracks the pointer distance
   a_count_ptr: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) || (count_ff == FIFO_CNT_W'(FIFO_DEPTH)) |->
         wr_ptr_ff == rd_ptr_ff)
      else $error("result queue pointers out of step");

endmodule

### hw/rtl/heat_stencil_2d_step_top.sv
// Five-point explicit heat update over a raster grid stream: line store, window, control.
//
// Usage: the input channel (req_) carries the previous grid in raster order, ghost border
// included, (rows+2) x (cols+2) samples of signed Q16.16; req_first_of_grid marks the
// top-left ghost cell and restarts the position. After the last sample the position wraps.
// The result channel (rsp_) carries one item per interior point, with its one-based row and
// column, rsp_last_of_grid set on point (rows, cols). Border cells produce nothing.
// Sizes and the two Q0.16 coefficients are set over the csr_ port while no item is in
// flight; sizes of 0 act as 1 and sizes above 1024 act as 1024.
// Throughput: one sample per cycle while req_ready is high; the line store is a
// single-port-write, single-read memory touched once per sample, and a same-column
// rewrite by the sample accepted in the cycle before is forwarded. A result reaches
// rsp_valid from the accepting edge of the sample below-right of its point (the memory
// read shares that edge) through three arithmetic stages and the queue.
// When the receiver stalls, results collect in an 8-entry queue; req_ready drops once the
// queue plus the items in flight could fill it, and rises again as results drain.
// Reset: position goes to row 0, column 0, registers to 256/256/0/0. No clearing pass: a
// fill mark makes never-written line store columns read as zero.
module heat_stencil_2d_step_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [hs2d_pkg::VALUE_W-1:0]    req_sample,
   input  logic                                  req_first_of_grid,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [hs2d_pkg::VALUE_W-1:0]    rsp_new_value,
   output logic [hs2d_pkg::IDX_W-1:0]             rsp_out_row,
   output logic [hs2d_pkg::IDX_W-1:0]             rsp_out_col,
   output logic                                  rsp_last_of_grid,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [hs2d_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [hs2d_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [hs2d_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready
);
   import hs2d_pkg::*;

   // Configuration registers
   logic [SIZE_W-1:0] grid_rows_ff, grid_cols_ff;
   logic [COEF_W-1:0] coef_x_ff, coef_y_ff;
   reg_index_type     csr_index;
   logic              csr_write;

   // Position and size
   logic [ROW_W-1:0]  rows_eff, row_ff, row_in, cur_row;
   logic [ADDR_W-1:0] cols_eff, col_ff, col_in, cur_col;
   logic [ROW_W:0]    row_next, row_limit, row_last;
   logic [ADDR_W:0]   col_next, col_limit, col_last;
   logic              accept, emit, is_last;
   meta_type          meta_in;

   // Line store and stage 1
   logic [2*VALUE_W-1:0]      line_mem [STORE_DEPTH];
   logic [2*VALUE_W-1:0]      rd_data_ff, fwd_data_ff, rd_eff, wr_data;
   logic [FILL_W-1:0]         fill_ff;
   logic                      s1_valid_ff, s1_emit_ff, s1_fwd_ff, s1_hit_ff;
   logic [ADDR_W-1:0]         s1_addr_ff;
   logic signed [VALUE_W-1:0] s1_sample_ff;
   meta_type                  s1_meta_ff;
   logic signed [VALUE_W-1:0] top, mid;
   logic signed [VALUE_W-1:0] win_top_ff, win_mid_ff, win_bot_ff, win_mid2_ff;
   logic signed [DIFF_W-1:0]  dv, dh;

   // Back end
   logic                  arith_valid;
   rsp_item_type          arith_item, head_item;
   logic [1:0]            busy_count;
   logic [FIFO_CNT_W-1:0] fifo_count;
   logic [2:0]            inflight;
   logic [FIFO_CNT_W:0]   credit_sum;

   // Register access
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= SIZE_W'(SIZE_RESET);
         grid_cols_ff <= SIZE_W'(SIZE_RESET);
         coef_x_ff    <= '0;
         coef_y_ff    <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_GRID_ROWS: grid_rows_ff <= csr_pwdata[SIZE_W-1:0];
            REG_GRID_COLS: grid_cols_ff <= csr_pwdata[SIZE_W-1:0];
            REG_COEF_X:    coef_x_ff    <= csr_pwdata[COEF_W-1:0];
            REG_COEF_Y:    coef_y_ff    <= csr_pwdata[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         REG_GRID_ROWS: csr_prdata = CSR_DATA_W'(grid_rows_ff);
         REG_GRID_COLS: csr_prdata = CSR_DATA_W'(grid_cols_ff);
         REG_COEF_X:    csr_prdata = CSR_DATA_W'(coef_x_ff);
         REG_COEF_Y:    csr_prdata = CSR_DATA_W'(coef_y_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // Clamp the sizes to 1..max
   always_comb begin
      if (grid_rows_ff == '0) begin
         rows_eff = ROW_W'(1);
      end else if (int'(grid_rows_ff) > MAX_ROWS) begin
         rows_eff = ROW_W'(MAX_ROWS);
      end else begin
         rows_eff = ROW_W'(grid_rows_ff);
      end
      if (grid_cols_ff == '0) begin
         cols_eff = ADDR_W'(1);
      end else if (int'(grid_cols_ff) > MAX_COLS) begin
         cols_eff = ADDR_W'(MAX_COLS);
      end else begin
         cols_eff = ADDR_W'(grid_cols_ff);
      end
   end

   // Raster position of the incoming item and its successor
   assign accept    = req_valid && req_ready;
   assign cur_row   = req_first_of_grid ? '0 : row_ff;
   assign cur_col   = req_first_of_grid ? '0 : col_ff;
   assign row_next  = {1'b0, cur_row} + (ROW_W+1)'(1);
   assign col_next  = {1'b0, cur_col} + (ADDR_W+1)'(1);
   assign row_limit = {1'b0, rows_eff} + (ROW_W+1)'(2);
   assign col_limit = {1'b0, cols_eff} + (ADDR_W+1)'(2);
   assign row_last  = {1'b0, rows_eff} + (ROW_W+1)'(1);
   assign col_last  = {1'b0, cols_eff} + (ADDR_W+1)'(1);

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (accept) begin
         if (col_next >= col_limit) begin
            col_in = '0;
            row_in = (row_next >= row_limit) ? '0 : row_next[ROW_W-1:0];
         end else begin
            col_in = col_next[ADDR_W-1:0];
            row_in = cur_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // Decide whether this item completes an interior point
   always_comb begin
      emit = (cur_row >= ROW_W'(2)) && ({1'b0, cur_row} <= row_last) &&
             (cur_col >= ADDR_W'(2)) && ({1'b0, cur_col} <= col_last);
      is_last      = ({1'b0, cur_row} == row_last) && ({1'b0, cur_col} == col_last);
      meta_in.row  = IDX_W'(cur_row - ROW_W'(1));
      meta_in.col  = IDX_W'(cur_col - ADDR_W'(1));
      meta_in.last = is_last;
   end

   // Stage 1 control: capture the item, flag forwarding and fill coverage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_emit_ff  <= 1'b0;
         s1_fwd_ff   <= 1'b0;
         s1_hit_ff   <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s1_emit_ff  <= accept && emit;
         s1_fwd_ff   <= accept && s1_valid_ff && (s1_addr_ff == cur_col);
         s1_hit_ff   <= FILL_W'(cur_col) < fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff   <= cur_col;
         s1_sample_ff <= req_sample;
         s1_meta_ff   <= meta_in;
         fwd_data_ff  <= wr_data;
      end
   end

   // Line store: upper row in the high half, middle row in the low half
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= line_mem[cur_col];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         line_mem[s1_addr_ff] <= wr_data;
      end
   end

   // Columns written since reset always form a prefix; track its length
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (s1_valid_ff && (FILL_W'(s1_addr_ff) >= fill_ff)) begin
         fill_ff <= FILL_W'(s1_addr_ff) + FILL_W'(1);
      end
   end

   // Select forwarded, stored or never-written column data
   always_comb begin
      if (s1_fwd_ff) begin
         rd_eff = fwd_data_ff;
      end else if (s1_hit_ff) begin
         rd_eff = rd_data_ff;
      end else begin
         rd_eff = '0;
      end
      top     = rd_eff[2*VALUE_W-1:VALUE_W];
      mid     = rd_eff[VALUE_W-1:0];
      wr_data = {mid, s1_sample_ff};
   end

   // Shift the 3x3 window by one column
   always_ff @(posedge clock) begin
      if (reset) begin
         win_top_ff  <= '0;
         win_mid_ff  <= '0;
         win_bot_ff  <= '0;
         win_mid2_ff <= '0;
      end else if (s1_valid_ff) begin
         win_mid2_ff <= win_mid_ff;
         win_top_ff  <= top;
         win_mid_ff  <= mid;
         win_bot_ff  <= s1_sample_ff;
      end
   end

   // Second differences along both axes
   always_comb begin
      dv = DIFF_W'(win_top_ff) + DIFF_W'(win_bot_ff) - (DIFF_W'(win_mid_ff) <<< 1);
      dh = DIFF_W'(win_mid2_ff) + DIFF_W'(mid) - (DIFF_W'(win_mid_ff) <<< 1);
   end

   hs2d_arith u_arith (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s1_emit_ff),
      .in_dv      (dv),
      .in_dh      (dh),
      .in_p       (win_mid_ff),
      .in_meta    (s1_meta_ff),
      .coef_x     (coef_x_ff),
      .coef_y     (coef_y_ff),
      .out_valid  (arith_valid),
      .out_item   (arith_item),
      .busy_count (busy_count)
   );

   hs2d_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (arith_valid),
      .push_item  (arith_item),
      .pop        (rsp_ready),
      .head_valid (rsp_valid),
      .head_item  (head_item),
      .count      (fifo_count)
   );

   assign rsp_new_value    = head_item.new_value;
   assign rsp_out_row      = head_item.out_row;
   assign rsp_out_col      = head_item.out_col;
   assign rsp_last_of_grid = head_item.last_of_grid;

   // Hold off new items once queued plus in-flight results could fill the queue
   always_comb begin
      inflight   = 3'(busy_count) + 3'(s1_emit_ff);
      credit_sum = (FIFO_CNT_W+1)'(fifo_count) + (FIFO_CNT_W+1)'(inflight);
      req_ready  = credit_sum < (FIFO_CNT_W+1)'(FIFO_DEPTH);
   end

   // Queue reservation never overcommits
   a_credit: assert property (@(posedge clock) disable iff (reset)
      credit_sum <= (FIFO_CNT_W+1)'(FIFO_DEPTH))
      else $error("result credits overcommitted");

   // Fill mark stays within the line store
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(STORE_DEPTH))
      else $error("line store fill mark out of range");

   // A written column is covered by the fill mark from then on
   a_fill_cover: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |=> fill_ff > FILL_W'($past(s1_addr_ff)))
      else $error("written column not covered by fill mark");

   // Forwarding only follows an item written in the preceding cycle
   a_fwd_pair: assert property (@(posedge clock) disable iff (reset)
      s1_fwd_ff |-> s1_valid_ff && $past(s1_valid_ff))
      else $error("forwarding without a preceding write");

endmodule
